/* design/swsmm_pkg.sv */
`timescale 1ns / 1ps

package swsmm_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 38;
    localparam int COUNT_W  = 7;
    localparam int IDX_W    = 6;
    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [COUNT_W-1:0] WLEN_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef struct packed {
        logic capture;
        logic act;
        logic repl;
        logic scan;
        logic load_out;
        logic cfg_we;
    } t_cmd;

    typedef struct packed {
        logic need_repl;
        logic scan_last;
    } t_status;

    // ring position of the k-th oldest sample, k < len
    function automatic logic [COUNT_W-1:0] ring_pos(
        input logic [COUNT_W-1:0] oldest,
        input logic [COUNT_W-1:0] k,
        input logic [COUNT_W-1:0] len
    );
        logic [COUNT_W:0] p;
        p = {1'b0, oldest} + {1'b0, k};
        if (p >= {1'b0, len}) begin
            p = p - {1'b0, len};
        end
        return p[COUNT_W-1:0];
    endfunction

endpackage

/* design/sliding_window_sum_min_max.sv */
`timescale 1ns / 1ps

// Sliding window of the last window_length signed samples with running sum,
// max, min, fill level and an indexed element read counted from the oldest.
// One item is handled at a time, in the steps capture, action, replace (only
// for an add on a full window, where it drops the oldest sample), scan, drain
// and load. The scan runs over the fill level after the action and reads the
// sample memory through its single read port one stored sample per cycle;
// the replace step uses the read of the sample being dropped.
// The result sits in an output register, so the next item is taken while it
// waits. A write to window_length empties the window; lengths above DEPTH act
// as DEPTH.
module sliding_window_sum_min_max
    import swsmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IDX_W-1:0]           i_read_index,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SUM_W-1:0]    o_window_sum,
    output logic signed [SAMPLE_W-1:0] o_window_max,
    output logic signed [SAMPLE_W-1:0] o_window_min,
    output logic                       o_is_full,
    output logic [COUNT_W-1:0]         o_fill_level,
    output logic signed [SAMPLE_W-1:0] o_element,
    output logic                       o_element_valid,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [COUNT_W-1:0]         i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    swsmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid)
    );

    swsmm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_sample        (i_sample),
        .i_read_index    (i_read_index),
        .o_window_sum    (o_window_sum),
        .o_window_max    (o_window_max),
        .o_window_min    (o_window_min),
        .o_is_full       (o_is_full),
        .o_fill_level    (o_fill_level),
        .o_element       (o_element),
        .o_element_valid (o_element_valid)
    );

endmodule

/* design/swsmm_ctrl.sv */
`timescale 1ns / 1ps

module swsmm_ctrl
    import swsmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cfg_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_cfg_ready,
    output logic    o_out_valid
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACT   = 6'b000010,
        ST_REPL  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   idle;
    logic   out_free;

    assign idle        = (r_state == ST_IDLE);
    // config goes first when both show up in the same cycle
    assign o_in_stall  = !idle || i_cfg_valid;
    assign o_cfg_ready = idle;
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.cfg_we = i_cfg_valid && idle;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_ACT;
                end
            end
            ST_ACT: begin
                o_cmd.act = 1'b1;
                n_state = i_status.need_repl ? ST_REPL : ST_SCAN;
            end
            ST_REPL: begin
                o_cmd.repl = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_act_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACT) |-> $past(o_cmd.capture))
        else $error("action step without a captured beat");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

/* design/swsmm_dp.sv */
`timescale 1ns / 1ps

module swsmm_dp
    import swsmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic [COUNT_W-1:0]         i_cfg_data,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IDX_W-1:0]           i_read_index,
    output logic signed [SUM_W-1:0]    o_window_sum,
    output logic signed [SAMPLE_W-1:0] o_window_max,
    output logic signed [SAMPLE_W-1:0] o_window_min,
    output logic                       o_is_full,
    output logic [COUNT_W-1:0]         o_fill_level,
    output logic signed [SAMPLE_W-1:0] o_element,
    output logic                       o_element_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_CAP =
        (DEPTH > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(DEPTH);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    logic [COUNT_W-1:0]         r_wl;
    logic [COUNT_W-1:0]         r_count;
    logic [COUNT_W-1:0]         r_oldest;
    logic signed [SUM_W-1:0]    r_sum;
    logic [ACTION_W-1:0]        r_action;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [IDX_W-1:0]           r_idx;
    logic [COUNT_W-1:0]         r_k;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_valid;
    logic [COUNT_W-1:0]         r_rd_k;
    logic signed [SAMPLE_W-1:0] r_mx;
    logic signed [SAMPLE_W-1:0] r_mn;
    logic signed [SAMPLE_W-1:0] r_el;

    logic signed [SUM_W-1:0]    r_out_sum;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic signed [SAMPLE_W-1:0] r_out_min;
    logic                       r_out_full;
    logic [COUNT_W-1:0]         r_out_fill;
    logic signed [SAMPLE_W-1:0] r_out_el;
    logic                       r_out_el_valid;

    logic [COUNT_W-1:0] len;
    logic               is_add;
    logic               is_clear;
    logic               len_zero;
    logic               win_full;
    logic               add_fill;
    logic               scan_issue;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [COUNT_W-1:0] fill_pos;
    logic [COUNT_W-1:0] scan_pos;
    logic [COUNT_W-1:0] oldest_inc;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic               el_valid;

    assign len      = (r_wl > DEPTH_CAP) ? DEPTH_CAP : r_wl;
    assign is_add   = (r_action == ACT_ADD);
    assign is_clear = (r_action == ACT_CLEAR);
    assign len_zero = (len == '0);
    assign win_full = (r_count == len);
    assign add_fill = i_cmd.act && is_add && !len_zero && !win_full;

    assign o_status.need_repl = is_add && !len_zero && win_full;
    assign o_status.scan_last = (({1'b0, r_k} + 1'b1) >= {1'b0, r_count});

    assign scan_issue = i_cmd.scan && (r_k < r_count);
    assign fill_pos   = ring_pos(r_oldest, r_count, len);
    assign scan_pos   = ring_pos(r_oldest, r_k, len);
    assign oldest_inc = r_oldest + 1'b1;

    assign mem_we  = add_fill || i_cmd.repl;
    assign wr_addr = add_fill ? AW'(fill_pos) : AW'(r_oldest);
    // outside a scan the port reads the oldest cell for a replacing add
    assign rd_addr = i_cmd.scan ? AW'(scan_pos) : AW'(r_oldest);

    assign sample_ext = {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
    assign old_ext    = {{(SUM_W-SAMPLE_W){r_rd_data[SAMPLE_W-1]}}, r_rd_data};
    assign el_valid   = ({1'b0, r_idx} < len) && ({1'b0, r_idx} < r_count);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl     <= WLEN_RESET;
            r_count  <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else if (i_cmd.cfg_we) begin
            r_wl     <= i_cfg_data;
            r_count  <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else if (i_cmd.act && is_clear) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else if (add_fill) begin
            r_count  <= r_count + 1'b1;
            r_sum    <= r_sum + sample_ext;
        end else if (i_cmd.repl) begin
            r_sum    <= r_sum + sample_ext - old_ext;
            r_oldest <= (oldest_inc >= len) ? '0 : oldest_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_sample <= i_sample;
            r_idx    <= i_read_index;
        end
    end

    // scan counter and read pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= scan_issue;
            if (i_cmd.act) begin
                r_k <= '0;
            end else if (scan_issue) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // fold each sample in the cycle after its read
    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (i_cmd.act) begin
            r_mx <= SAMPLE_MIN;
            r_mn <= SAMPLE_MAX;
            r_el <= SAMPLE_MIN;
        end else if (r_rd_valid) begin
            if (r_rd_data > r_mx) begin
                r_mx <= r_rd_data;
            end
            if (r_rd_data < r_mn) begin
                r_mn <= r_rd_data;
            end
            if (r_rd_k == COUNT_W'(r_idx)) begin
                r_el <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sum      <= r_sum;
            r_out_max      <= r_mx;
            r_out_min      <= r_mn;
            r_out_full     <= !len_zero && win_full;
            r_out_fill     <= r_count;
            r_out_el       <= el_valid ? r_el : SAMPLE_MIN;
            r_out_el_valid <= el_valid;
        end
    end

    assign o_window_sum    = r_out_sum;
    assign o_window_max    = r_out_max;
    assign o_window_min    = r_out_min;
    assign o_is_full       = r_out_full;
    assign o_fill_level    = r_out_fill;
    assign o_element       = r_out_el;
    assign o_element_valid = r_out_el_valid;

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= len)
        else $error("fill count above window length");

    a_oldest_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest == '0) || (r_oldest < len))
        else $error("oldest pointer outside window");

    a_repl_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.repl |-> (win_full && !len_zero))
        else $error("replacing add on a window that is not full");

    a_fold_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_rd_valid)
        else $error("result loaded while a scan read is still in flight");

endmodule

/* tb/sliding_window_sum_min_max_tb.sv */
`timescale 1ns / 1ps

module sliding_window_sum_min_max_tb;
    import swsmm_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_COUNT = 15;

    typedef struct {
        logic signed [SUM_W-1:0]    win_sum;
        logic signed [SAMPLE_W-1:0] win_max;
        logic signed [SAMPLE_W-1:0] win_min;
        logic                       full;
        logic [COUNT_W-1:0]         fill;
        logic signed [SAMPLE_W-1:0] elem;
        logic                       elem_ok;
    } window_result_t;

    class window_scoreboard;
        logic signed [SAMPLE_W-1:0] cells [DEPTH_DEFAULT];
        logic [COUNT_W-1:0]         span;
        logic [COUNT_W-1:0]         fill;
        logic [COUNT_W-1:0]         oldest;
        logic signed [SUM_W-1:0]    total;
        window_result_t             expected_q [$];
        int                         errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            span   = WLEN_RESET;
            fill   = '0;
            oldest = '0;
            total  = '0;
            errors = 0;
        endfunction

        function void clear_window();
            fill   = '0;
            oldest = '0;
            total  = '0;
        endfunction

        function void set_length(logic [COUNT_W-1:0] v);
            span = (v > DEPTH_DEFAULT) ? COUNT_W'(DEPTH_DEFAULT) : v;
            clear_window();
        endfunction

        // ring cell of the k-th oldest sample
        function logic [IDX_W-1:0] slot(logic [COUNT_W-1:0] k);
            logic [COUNT_W:0] p;
            p = {1'b0, oldest} + {1'b0, k};
            if (p >= {1'b0, span}) begin
                p = p - {1'b0, span};
            end
            return p[IDX_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic signed [SAMPLE_W-1:0] s,
                                logic [IDX_W-1:0] idx);
            window_result_t             r;
            logic [IDX_W-1:0]           p;
            logic signed [SAMPLE_W-1:0] v;
            if (act == ACT_ADD && span != 0) begin
                if (fill < span) begin
                    cells[slot(fill)] = s;
                    fill  = fill + 1'b1;
                    total = total + s;
                end else begin
                    // full window: overwrite the oldest and move the head on
                    p         = oldest[IDX_W-1:0];
                    total     = total + s - cells[p];
                    cells[p]  = s;
                    oldest    = (oldest + 1 >= span) ? '0 : oldest + 1'b1;
                end
            end else if (act == ACT_CLEAR) begin
                clear_window();
            end
            r.win_sum = total;
            r.win_max = SAMPLE_MIN;
            r.win_min = SAMPLE_MAX;
            for (int k = 0; k < fill; k++) begin
                v = cells[slot(COUNT_W'(k))];
                if (v > r.win_max) r.win_max = v;
                if (v < r.win_min) r.win_min = v;
            end
            r.full    = (span != 0) && (fill == span);
            r.fill    = fill;
            r.elem_ok = (idx < span) && (idx < fill);
            r.elem    = r.elem_ok ? cells[slot({1'b0, idx})] : SAMPLE_MIN;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] e, logic signed [63:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(window_result_t got);
            window_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got sum %0d", $time, got.win_sum);
                return;
            end
            e = expected_q.pop_front();
            compare_field("window_sum", e.win_sum, got.win_sum);
            compare_field("window_max", e.win_max, got.win_max);
            compare_field("window_min", e.win_min, got.win_min);
            compare_field("is_full", e.full, got.full);
            compare_field("fill_level", e.fill, got.fill);
            compare_field("element", e.elem, got.elem);
            compare_field("element_valid", e.elem_ok, got.elem_ok);
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [ACTION_W-1:0]        i_action;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [IDX_W-1:0]           i_read_index;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SUM_W-1:0]    o_window_sum;
    logic signed [SAMPLE_W-1:0] o_window_max;
    logic signed [SAMPLE_W-1:0] o_window_min;
    logic                       o_is_full;
    logic [COUNT_W-1:0]         o_fill_level;
    logic signed [SAMPLE_W-1:0] o_element;
    logic                       o_element_valid;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [COUNT_W-1:0]         i_cfg_data;

    window_scoreboard sb = new();
    bit               calm = 1'b0;
    int               quiet_cycles = 0;
    logic [COUNT_W-1:0] phase_len [PHASE_COUNT] = '{
        7'd5, 7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd16, 7'd2,
        7'd100, 7'd8, 7'd63, 7'd33, 7'd12, 7'd7, 7'd4
    };

    sliding_window_sum_min_max i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_sample        (i_sample),
        .i_read_index    (i_read_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_window_sum    (o_window_sum),
        .o_window_max    (o_window_max),
        .o_window_min    (o_window_min),
        .o_is_full       (o_is_full),
        .o_fill_level    (o_fill_level),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    always @(posedge i_clk) begin
        window_result_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.win_sum = o_window_sum;
            got.win_max = o_window_max;
            got.win_min = o_window_min;
            got.full    = o_is_full;
            got.fill    = o_fill_level;
            got.elem    = o_element;
            got.elem_ok = o_element_valid;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [ACTION_W-1:0] act, input logic signed [SAMPLE_W-1:0] s,
                        input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_sample     <= s;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(act, s, idx);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_length(input logic [COUNT_W-1:0] v);
        drain();
        // let the block settle before touching the register
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_length(v);
    endtask

    initial begin
        logic [ACTION_W-1:0]        act;
        logic signed [SAMPLE_W-1:0] s;
        logic [IDX_W-1:0]           idx;
        int                         eff;
        int                         n_items;
        int                         r;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_READ;
        i_sample     <= '0;
        i_read_index <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        phase_len[12] = COUNT_W'($urandom_range(0, 127));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length, empty window and extremes
        send(ACT_READ, 32'sd0, 6'd0);
        send(ACT_SPARE, 32'sd0, 6'd63);
        send(ACT_ADD, SAMPLE_MAX, 6'd0);
        send(ACT_ADD, SAMPLE_MIN, 6'd1);
        send(ACT_ADD, 32'sd0, 6'd2);
        send(ACT_ADD, -32'sd1, 6'd3);
        send(ACT_READ, 32'sd0, 6'd4);
        send(ACT_READ, 32'sd0, 6'd63);
        send(ACT_CLEAR, 32'sd0, 6'd0);
        send(ACT_ADD, 32'sh5555_5555, 6'd0);

        // zero length ignores adds
        write_length(7'd0);
        send(ACT_ADD, 32'sd7, 6'd0);
        send(ACT_READ, 32'sd0, 6'd0);

        write_length(7'd1);
        send(ACT_ADD, 32'sd42, 6'd0);
        send(ACT_ADD, -32'sd42, 6'd0);
        send(ACT_READ, 32'sd0, 6'd1);

        // wrap of a short ring
        write_length(7'd3);
        send(ACT_ADD, 32'sd1, 6'd0);
        send(ACT_ADD, 32'sd2, 6'd1);
        send(ACT_ADD, 32'sd3, 6'd2);
        send(ACT_ADD, 32'sd4, 6'd2);
        send(ACT_SPARE, 32'sd0, 6'd2);
        send(ACT_CLEAR, 32'sd0, 6'd0);

        // length above the ring depth
        write_length(7'd127);
        send(ACT_ADD, SAMPLE_MAX, 6'd63);
        send(ACT_READ, 32'sd0, 6'd0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            calm = (ph == 6);
            write_length(phase_len[ph]);
            eff     = (phase_len[ph] > DEPTH_DEFAULT) ? DEPTH_DEFAULT : phase_len[ph];
            n_items = (eff > 40) ? 160 : 85;
            for (int i = 0; i < n_items; i++) begin
                if (ph == 4 && i == n_items / 2) drain();
                r = $urandom_range(0, 99);
                if (r < 72) act = ACT_ADD;
                else if (r < 77) act = ACT_CLEAR;
                else if (r < 95) act = ACT_READ;
                else act = ACT_SPARE;
                case ($urandom_range(0, 7))
                    0: s = SAMPLE_MIN;
                    1: s = SAMPLE_MAX;
                    2: s = 32'sd0;
                    3: s = -32'sd1;
                    4: s = $signed($urandom_range(0, 200)) - 32'sd100;
                    default: s = $urandom;
                endcase
                if (eff > 0 && $urandom_range(0, 1) == 1) begin
                    idx = IDX_W'($urandom_range(0, eff));
                end else begin
                    idx = IDX_W'($urandom);
                end
                send(act, s, idx);
            end
        end
        calm = 1'b0;

        drain();
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
design/swsmm_pkg.sv
design/swsmm_ctrl.sv
design/swsmm_dp.sv
design/sliding_window_sum_min_max.sv
tb/sliding_window_sum_min_max_tb.sv
